// ----- hw/rtl/vicinity_tag_block_store_assert.svh -----
// ----------------------------------------------------------------------------
// Vicinity tag block store - assertion macros
// Shorthand for clocked implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef VICINITY_TAG_BLOCK_STORE_ASSERT_SVH
`define VICINITY_TAG_BLOCK_STORE_ASSERT_SVH

// Same-cycle implication.
`define VTBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define VTBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/vtbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtbs_pkg
// Shared types, command codes and constants of the vicinity tag block store.
// ----------------------------------------------------------------------------
package vtbs_pkg;

    localparam int VTBS_NUM_BLOCKS = 64;
    localparam int VTBS_WORD_W     = 32;
    // Stored entry: user lock bit above the data word.
    localparam int VTBS_ENTRY_W    = VTBS_WORD_W + 1;

    // Command codes
    localparam logic [3:0] OP_READ_SINGLE  = 4'd0;
    localparam logic [3:0] OP_WRITE_SINGLE = 4'd1;
    localparam logic [3:0] OP_LOCK_BLOCK   = 4'd2;
    localparam logic [3:0] OP_READ_MULTI   = 4'd3;
    localparam logic [3:0] OP_SECURITY     = 4'd4;
    localparam logic [3:0] OP_WRITE_AFI    = 4'd5;
    localparam logic [3:0] OP_LOCK_AFI     = 4'd6;
    localparam logic [3:0] OP_WRITE_DSFID  = 4'd7;
    localparam logic [3:0] OP_LOCK_DSFID   = 4'd8;

    // Response kinds
    localparam logic [1:0] KIND_SILENT = 2'd0;
    localparam logic [1:0] KIND_OK     = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_BLOCK  = 2'd3;

    localparam logic [7:0] ERR_NONE         = 8'h00;
    localparam logic [7:0] ERR_OUT_OF_RANGE = 8'h0F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DATA
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_ram_ctl;

    // Parameter byte count each command expects.
    function automatic logic [3:0] f_param_len(input logic [3:0] op);
        logic [3:0] len;
        unique case (op)
            OP_READ_SINGLE, OP_LOCK_BLOCK,
            OP_WRITE_AFI, OP_WRITE_DSFID:  len = 4'd1;
            OP_WRITE_SINGLE:               len = 4'd5;
            OP_READ_MULTI, OP_SECURITY:    len = 4'd2;
            default:                       len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/vtbs_block_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtbs_block_ram
// Block store: one write port, one registered read port, per-entry valid bits
// so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module vtbs_block_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int WIDTH = 33
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vtbs_pkg::t_ram_ctl i_ctl,
    input  logic [AW-1:0]      i_rd_addr,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [WIDTH-1:0]   i_wr_data,
    output logic [WIDTH-1:0]   o_rd_data
);
    import vtbs_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

// ----- hw/rtl/vicinity_tag_block_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vicinity_tag_block_store
// Memory side of a vicinity tag: data blocks with user and factory locks,
// AFI and DSFID bytes with lock flags, answering decoded requests.
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low. Each result
// entry appears for exactly one cycle with o_strobe high; there is no
// back-pressure, so the receiver must take every entry as it comes. The final
// entry of a request has o_last set. Commands that need no block access
// (AFI/DSFID, bad length, out of range) answer from the issue state;
// single-block commands read the block there and answer from the data state;
// read multiple and security status then give one entry per cycle, fetching
// the next block while each entry is sent. That rate is set by the single
// read port of the block memory, one block per cycle.
// o_busy drops in the cycle the final entry is shown, so the next request
// may be taken then. o_current_afi/o_current_dsfid always show the stored
// values. The factory lock mask is written through the cfg channel, which is
// always ready; write it only while no request is in flight.
// ----------------------------------------------------------------------------
`include "vicinity_tag_block_store_assert.svh"

module vicinity_tag_block_store #(
    parameter int NUM_BLOCKS = vtbs_pkg::VTBS_NUM_BLOCKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_start,
    output logic        o_busy,
    input  logic [3:0]  i_opcode,
    input  logic [7:0]  i_block_index,
    input  logic [7:0]  i_count_minus_one,
    input  logic [31:0] i_write_word,
    input  logic [7:0]  i_id_byte,
    input  logic [3:0]  i_param_bytes,
    input  logic        i_option_flag,
    input  logic        i_addressed,
    // factory lock mask
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data,
    // result channel
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_error_code,
    output logic [1:0]  o_lock_status,
    output logic        o_has_lock,
    output logic        o_has_data,
    output logic [31:0] o_block_data,
    output logic [7:0]  o_current_afi,
    output logic [7:0]  o_current_dsfid,
    output logic        o_last
);
    import vtbs_pkg::*;

    localparam int         AW       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam logic [8:0] NUM_B9   = 9'(NUM_BLOCKS);
    localparam logic [8:0] LAST_B9  = 9'(NUM_BLOCKS - 1);
    localparam logic [AW-1:0] LAST_A = AW'(NUM_BLOCKS - 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    // latched request
    logic [3:0]  r_op;
    logic [7:0]  r_blk;
    logic [7:0]  r_cnt;
    logic [31:0] r_word;
    logic [7:0]  r_idb;
    logic [3:0]  r_plen;
    logic        r_opt;
    logic        r_addressed;

    // walk through blocks
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_end,  n_end;

    // AFI / DSFID
    logic [7:0] r_afi, n_afi;
    logic [7:0] r_dsfid, n_dsfid;
    logic       r_afi_lock, n_afi_lock;
    logic       r_dsfid_lock, n_dsfid_lock;

    logic [63:0] r_factory;

    // result register
    logic        r_strobe, n_strobe;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_err, n_err;
    logic [1:0]  r_lock, n_lock;
    logic        r_has_lock, n_has_lock;
    logic        r_has_data, n_has_data;
    logic [31:0] r_data, n_data;
    logic        r_last, n_last;

    // memory port
    t_ram_ctl                 w_ram_ctl;
    logic [AW-1:0]            w_rd_addr;
    logic [VTBS_ENTRY_W-1:0]  w_wr_data;
    logic [VTBS_ENTRY_W-1:0]  w_rd_data;

    // decode of the latched request
    logic       w_accept;
    logic       w_plen_ok;
    logic       w_in_range;
    logic       w_go_read;
    logic [1:0] w_issue_kind;
    logic [7:0] w_issue_err;
    logic [8:0] w_sum;
    logic       w_user;
    logic       w_fact;
    logic       w_at_end;
    logic       w_multi;

    assign w_accept    = i_start && (r_state == ST_IDLE);
    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Block memory: {user lock, data word}
    // ------------------------------------------------------------------
    vtbs_block_ram #(
        .DEPTH (NUM_BLOCKS),
        .AW    (AW),
        .WIDTH (VTBS_ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ram_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (r_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign w_plen_ok  = (r_plen == f_param_len(r_op));
    assign w_in_range = ({1'b0, r_blk} < NUM_B9);
    assign w_sum      = {1'b0, r_blk} + {1'b0, r_cnt};
    assign w_user     = w_rd_data[VTBS_WORD_W];
    assign w_fact     = r_factory[r_addr];
    assign w_at_end   = (r_addr == r_end);
    assign w_multi    = (r_op == OP_READ_MULTI) || (r_op == OP_SECURITY);

    // Which requests touch the block memory, and the single answer for
    // those that do not.
    always_comb begin
        w_go_read    = 1'b0;
        w_issue_kind = KIND_SILENT;
        w_issue_err  = ERR_NONE;
        priority if (!w_plen_ok) begin
            w_go_read = 1'b0;
        end else if (r_op == OP_READ_SINGLE || r_op == OP_READ_MULTI) begin
            if (w_in_range) begin
                w_go_read = 1'b1;
            end else if (r_addressed) begin
                w_issue_kind = KIND_ERROR;
                w_issue_err  = ERR_OUT_OF_RANGE;
            end
        end else if (r_op == OP_WRITE_SINGLE || r_op == OP_LOCK_BLOCK ||
                     r_op == OP_SECURITY) begin
            w_go_read = w_in_range;
        end else begin
            w_go_read = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                n_state = w_go_read ? ST_DATA : ST_IDLE;
            end
            ST_DATA: begin
                if (!w_multi || w_at_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and result
    // ------------------------------------------------------------------
    always_comb begin
        w_ram_ctl    = '0;
        w_rd_addr    = r_addr;
        w_wr_data    = {1'b0, r_word};
        n_addr       = r_addr;
        n_end        = r_end;
        n_afi        = r_afi;
        n_dsfid      = r_dsfid;
        n_afi_lock   = r_afi_lock;
        n_dsfid_lock = r_dsfid_lock;
        n_strobe     = 1'b0;
        n_kind       = KIND_SILENT;
        n_err        = ERR_NONE;
        n_lock       = 2'b00;
        n_has_lock   = 1'b0;
        n_has_data   = 1'b0;
        n_data       = '0;
        n_last       = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                // nothing to do until a request arrives
            end
            ST_ISSUE: begin
                // clip the range at the end of memory
                n_end = (w_sum >= LAST_B9) ? LAST_A : w_sum[AW-1:0];
                n_addr = r_blk[AW-1:0];
                if (w_go_read) begin
                    w_ram_ctl.rd_en = 1'b1;
                    w_rd_addr       = r_blk[AW-1:0];
                end else begin
                    n_strobe = 1'b1;
                    n_kind   = w_issue_kind;
                    n_err    = w_issue_err;
                    if (w_plen_ok) begin
                        priority if (r_op == OP_WRITE_AFI) begin
                            if (!r_afi_lock) n_afi = r_idb;
                        end else if (r_op == OP_LOCK_AFI) begin
                            n_afi_lock = 1'b1;
                        end else if (r_op == OP_WRITE_DSFID) begin
                            if (!r_dsfid_lock) n_dsfid = r_idb;
                        end else if (r_op == OP_LOCK_DSFID) begin
                            n_dsfid_lock = 1'b1;
                        end else begin
                            n_kind = w_issue_kind;
                        end
                    end
                end
            end
            ST_DATA: begin
                n_strobe = 1'b1;
                unique case (r_op)
                    OP_READ_SINGLE: begin
                        n_kind     = KIND_BLOCK;
                        n_has_data = 1'b1;
                        n_data     = w_rd_data[VTBS_WORD_W-1:0];
                        n_has_lock = r_opt;
                        // factory lock wins over user lock here
                        if (r_opt) begin
                            n_lock = w_fact ? 2'd2 : (w_user ? 2'd1 : 2'd0);
                        end
                    end
                    OP_WRITE_SINGLE: begin
                        if (!w_user && !w_fact) begin
                            w_ram_ctl.wr_en = 1'b1;
                            w_wr_data       = {1'b0, r_word};
                            n_kind          = KIND_OK;
                        end
                    end
                    OP_LOCK_BLOCK: begin
                        // tag stays silent either way
                        if (!w_user && !w_fact) begin
                            w_ram_ctl.wr_en = 1'b1;
                            w_wr_data = {1'b1, w_rd_data[VTBS_WORD_W-1:0]};
                        end
                    end
                    OP_READ_MULTI, OP_SECURITY: begin
                        n_kind = KIND_BLOCK;
                        n_last = w_at_end;
                        if (r_op == OP_READ_MULTI) begin
                            n_has_data = 1'b1;
                            n_data     = w_rd_data[VTBS_WORD_W-1:0];
                            n_has_lock = r_opt;
                            n_lock     = r_opt ? {w_fact, w_user} : 2'b00;
                        end else begin
                            n_has_lock = 1'b1;
                            n_lock     = {w_fact, w_user};
                        end
                        // fetch the next block while this one is sent
                        if (!w_at_end) begin
                            w_ram_ctl.rd_en = 1'b1;
                            w_rd_addr       = r_addr + AW'(1);
                            n_addr          = r_addr + AW'(1);
                        end
                    end
                    default: begin
                        n_kind = KIND_SILENT;
                    end
                endcase
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_strobe     <= 1'b0;
            r_afi        <= '0;
            r_dsfid      <= '0;
            r_afi_lock   <= 1'b0;
            r_dsfid_lock <= 1'b0;
            r_factory    <= '0;
        end else begin
            r_state      <= n_state;
            r_strobe     <= n_strobe;
            r_afi        <= n_afi;
            r_dsfid      <= n_dsfid;
            r_afi_lock   <= n_afi_lock;
            r_dsfid_lock <= n_dsfid_lock;
            if (i_cfg_valid && o_cfg_ready) begin
                r_factory <= i_cfg_data;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= i_opcode;
            r_blk       <= i_block_index;
            r_cnt       <= i_count_minus_one;
            r_word      <= i_write_word;
            r_idb       <= i_id_byte;
            r_plen      <= i_param_bytes;
            r_opt       <= i_option_flag;
            r_addressed <= i_addressed;
        end
        r_addr     <= n_addr;
        r_end      <= n_end;
        r_kind     <= n_kind;
        r_err      <= n_err;
        r_lock     <= n_lock;
        r_has_lock <= n_has_lock;
        r_has_data <= n_has_data;
        r_data     <= n_data;
        r_last     <= n_last;
    end

    assign o_strobe        = r_strobe;
    assign o_kind          = r_kind;
    assign o_error_code    = r_err;
    assign o_lock_status   = r_lock;
    assign o_has_lock      = r_has_lock;
    assign o_has_data      = r_has_data;
    assign o_block_data    = r_data;
    assign o_current_afi   = r_afi;
    assign o_current_dsfid = r_dsfid;
    assign o_last          = r_last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // a multi-block burst has no gaps
    `VTBS_ASSERT_NEXT(a_burst_contiguous, o_strobe && !o_last, o_strobe,
        "result burst broken before its last entry")
    // only block entries come in bursts
    `VTBS_ASSERT_SAME(a_single_nonblock, o_strobe && (o_kind != KIND_BLOCK), o_last,
        "non-block response not marked last")
    // memory is written only while the read data of the same block is in hand
    `VTBS_ASSERT_SAME(a_write_in_data, w_ram_ctl.wr_en, r_state == ST_DATA,
        "block memory written outside the data phase")
    // a new request never gets a result in the cycle after it is taken
    `VTBS_ASSERT_NEXT(a_no_early_result, i_start && !o_busy, !o_strobe,
        "result appeared one cycle after the request")

endmodule
